/* rtl/nss_pkg.sv */
// Shared constants and helper functions for the nine-slice rectangle splitter.
package nss_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int MARGIN_W       = 15;
   localparam int GRID           = 3;
   localparam int NUM_CELLS      = GRID * GRID;
   localparam int CELL_W         = 2;
   localparam int QUEUE_DEPTH    = 2;

   function automatic int edge_bits(int coord_bits);
      return ((coord_bits > MARGIN_W + 1) ? coord_bits : MARGIN_W + 1) + 3;
   endfunction

   function automatic int entry_bits(int coord_bits);
      return 4 * (GRID + 1) * coord_bits + 2 * GRID;
   endfunction

endpackage

/* rtl/nss_if.sv */
// Command and cell channel interfaces for the nine-slice rectangle splitter.
interface nss_req_if #(parameter int COORD_BITS = nss_pkg::COORD_BITS_DEF);
   import nss_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] dst_left;
   logic signed [COORD_BITS-1:0] dst_top;
   logic signed [COORD_BITS-1:0] dst_right;
   logic signed [COORD_BITS-1:0] dst_bottom;
   logic signed [COORD_BITS-1:0] source_left;
   logic signed [COORD_BITS-1:0] source_top;
   logic signed [COORD_BITS-1:0] source_right;
   logic signed [COORD_BITS-1:0] source_bottom;
   logic [MARGIN_W-1:0]          margin_left;
   logic [MARGIN_W-1:0]          margin_top;
   logic [MARGIN_W-1:0]          margin_right;
   logic [MARGIN_W-1:0]          margin_bottom;

   modport source (
      output valid, dst_left, dst_top, dst_right, dst_bottom,
             source_left, source_top, source_right, source_bottom,
             margin_left, margin_top, margin_right, margin_bottom,
      input  ready
   );

   modport sink (
      input  valid, dst_left, dst_top, dst_right, dst_bottom,
             source_left, source_top, source_right, source_bottom,
             margin_left, margin_top, margin_right, margin_bottom,
      output ready
   );
endinterface

interface nss_rsp_if #(parameter int COORD_BITS = nss_pkg::COORD_BITS_DEF);
   import nss_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] out_dst_left;
   logic signed [COORD_BITS-1:0] out_dst_top;
   logic signed [COORD_BITS-1:0] out_dst_right;
   logic signed [COORD_BITS-1:0] out_dst_bottom;
   logic signed [COORD_BITS-1:0] out_src_left;
   logic signed [COORD_BITS-1:0] out_src_top;
   logic signed [COORD_BITS-1:0] out_src_right;
   logic signed [COORD_BITS-1:0] out_src_bottom;
   logic [CELL_W-1:0]            cell_row;
   logic [CELL_W-1:0]            cell_col;
   logic                         last_cell;

   modport source (
      output valid, out_dst_left, out_dst_top, out_dst_right, out_dst_bottom,
             out_src_left, out_src_top, out_src_right, out_src_bottom,
             cell_row, cell_col, last_cell,
      input  ready
   );

   modport sink (
      input  valid, out_dst_left, out_dst_top, out_dst_right, out_dst_bottom,
             out_src_left, out_src_top, out_src_right, out_src_bottom,
             cell_row, cell_col, last_cell,
      output ready
   );
endinterface

/* rtl/nine_slice_rect_splitter.sv */
// Nine-slice rectangle splitter top level.
//
// req_bus takes one command per beat: destination and source rectangles and
// four margins. rsp_bus gives one beat per live cell, row-major, with
// last_cell set on the final beat of the command. A command whose source
// margins overlap, or whose cells are all empty, gives no beat at all.
// A command beat reaches its first cell beat through two front stages, the
// queue, the sequencer load and the output register.
// The sequencer emits one cell per cycle while rsp_bus is not stalled, so a
// command holds the cell channel for its live cells, one to nine; the front
// end takes a new command every cycle while the queue has room, and a queued
// command's first cell follows the previous last cell with no gap.
// When rsp_bus stalls, the output register holds its beat, the sequencer
// holds its place, the queue fills and req_bus.ready falls.
// Synchronous reset empties both pipeline stages, the queue, the sequencer mask
// and the output register; no other state is kept between commands.
module nine_slice_rect_splitter #(
   parameter int COORD_BITS  = nss_pkg::COORD_BITS_DEF,
   parameter int QUEUE_DEPTH = nss_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   nss_req_if.sink   req_bus,
   nss_rsp_if.source rsp_bus
);
   import nss_pkg::*;

   localparam int ENTRY_W = entry_bits(COORD_BITS);

   logic               push;
   logic [ENTRY_W-1:0] push_data;
   logic               queue_full;
   logic               pop;
   logic [ENTRY_W-1:0] pop_data;
   logic               pop_valid;

   nss_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   nss_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .pop_valid (pop_valid)
   );

   nss_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (pop_valid),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

/* rtl/nss_front.sv */
// Command front end: edge build, margin crop and cell classification, two stages.
module nss_front #(
   parameter int COORD_BITS = nss_pkg::COORD_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   nss_req_if.sink                                       req_bus,
   output logic                                          push,
   output logic [nss_pkg::entry_bits(COORD_BITS)-1:0]    push_data,
   input  logic                                          queue_full
);
   import nss_pkg::*;

   localparam int EDGE_W = edge_bits(COORD_BITS);

   typedef logic signed [EDGE_W-1:0]     edge_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type           lo;
      coord_type           hi;
      coord_type           src_lo;
      coord_type           src_hi;
      logic [MARGIN_W-1:0] m0;
      logic [MARGIN_W-1:0] m1;
   } axis_in_type;

   typedef struct packed {
      edge_type d0, d1, d2, d3;
      edge_type s0, s1, s2, s3;
      edge_type w;
      edge_type k;
      logic     ok;
      logic     over;
      logic     near;
      logic     far;
   } axis_edge_type;

   typedef struct packed {
      coord_type [GRID:0] d;
      coord_type [GRID:0] s;
      logic [GRID-1:0]    live;
      logic               ok;
   } axis_out_type;

   typedef struct packed {
      coord_type [GRID:0] xd;
      coord_type [GRID:0] xs;
      coord_type [GRID:0] yd;
      coord_type [GRID:0] ys;
      logic [GRID-1:0]    col_live;
      logic [GRID-1:0]    row_live;
   } cells_type;

   function automatic axis_edge_type build_edges(axis_in_type a);
      axis_edge_type e;
      edge_type      mm0;
      edge_type      mm1;
      mm0    = edge_type'(a.m0);
      mm1    = edge_type'(a.m1);
      e.d0   = edge_type'(a.lo);
      e.d3   = edge_type'(a.hi);
      e.d1   = e.d0 + mm0;
      e.d2   = e.d3 - mm1;
      e.s0   = edge_type'(a.src_lo);
      e.s3   = edge_type'(a.src_hi);
      e.s1   = e.s0 + mm0;
      e.s2   = e.s3 - mm1;
      e.ok   = (e.s0 <= e.s1) && (e.s1 <= e.s2) && (e.s2 <= e.s3);
      e.w    = e.d3 - e.d0;
      e.over = (mm0 + mm1) > e.w;
      e.near = mm0 >= e.w;
      e.far  = mm1 >= e.w;
      e.k    = e.w - mm0;
      return e;
   endfunction

   function automatic axis_out_type crop_edges(axis_edge_type e);
      axis_out_type o;
      edge_type     d [GRID+1];
      edge_type     s [GRID+1];
      d[0] = e.d0; d[1] = e.d1; d[2] = e.d2; d[3] = e.d3;
      s[0] = e.s0; s[1] = e.s1; s[2] = e.s2; s[3] = e.s3;
      if (e.over) begin
         if (e.near) begin
            s[1] = e.s0 + e.w; s[2] = e.s0 + e.w; s[3] = e.s0 + e.w;
            d[1] = e.d0 + e.w; d[2] = e.d0 + e.w; d[3] = e.d0 + e.w;
         end else if (e.far) begin
            s[0] = e.s3 - e.w; s[1] = e.s3 - e.w; s[2] = e.s3 - e.w;
            d[0] = e.d3 - e.w; d[1] = e.d3 - e.w; d[2] = e.d3 - e.w;
         end else begin
            s[2] = e.s3 - e.k;
            d[2] = e.d3 - e.k;
         end
      end
      for (int i = 0; i <= GRID; i++) begin
         o.d[i] = coord_type'(d[i]);
         o.s[i] = coord_type'(s[i]);
      end
      for (int i = 0; i < GRID; i++) begin
         o.live[i] = s[i] != s[i+1];
      end
      o.ok = e.ok;
      return o;
   endfunction

   logic          a_valid_ff, a_valid_in;
   axis_in_type   a_x_ff, a_y_ff;
   logic          b_valid_ff, b_valid_in;
   axis_edge_type b_x_ff, b_y_ff;

   logic          a_ready;
   logic          b_ready;
   logic          b_keep;
   axis_out_type  x_out, y_out;
   cells_type     entry;

   always_comb begin
      x_out          = crop_edges(b_x_ff);
      y_out          = crop_edges(b_y_ff);
      entry.xd       = x_out.d;
      entry.xs       = x_out.s;
      entry.yd       = y_out.d;
      entry.ys       = y_out.s;
      entry.col_live = x_out.live;
      entry.row_live = y_out.live;
      b_keep         = x_out.ok && y_out.ok && (|x_out.live) && (|y_out.live);
   end

   assign push          = b_valid_ff && b_keep && !queue_full;
   assign push_data     = entry;
   assign b_ready       = !b_valid_ff || !b_keep || !queue_full;
   assign a_ready       = !a_valid_ff || b_ready;
   assign req_bus.ready = a_ready;

   assign a_valid_in = a_ready ? req_bus.valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && req_bus.valid) begin
         a_x_ff <= '{lo: req_bus.dst_left, hi: req_bus.dst_right,
                     src_lo: req_bus.source_left, src_hi: req_bus.source_right,
                     m0: req_bus.margin_left, m1: req_bus.margin_right};
         a_y_ff <= '{lo: req_bus.dst_top, hi: req_bus.dst_bottom,
                     src_lo: req_bus.source_top, src_hi: req_bus.source_bottom,
                     m0: req_bus.margin_top, m1: req_bus.margin_bottom};
      end
      if (b_ready && a_valid_ff) begin
         b_x_ff <= build_edges(a_x_ff);
         b_y_ff <= build_edges(a_y_ff);
      end
   end

endmodule

/* rtl/nss_queue.sv */
// Short register queue between the command front end and the cell sequencer.
module nss_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = nss_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             pop_valid
);
   import nss_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* rtl/nss_back.sv */
// Cell sequencer: walks the live cells of one command and drives the cell channel.
module nss_back #(
   parameter int COORD_BITS = nss_pkg::COORD_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       q_valid,
   input  logic [nss_pkg::entry_bits(COORD_BITS)-1:0] q_data,
   output logic                                       q_pop,
   nss_rsp_if.source                                  rsp_bus
);
   import nss_pkg::*;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type [GRID:0] xd;
      coord_type [GRID:0] xs;
      coord_type [GRID:0] yd;
      coord_type [GRID:0] ys;
      logic [GRID-1:0]    col_live;
      logic [GRID-1:0]    row_live;
   } cells_type;

   typedef struct packed {
      coord_type         dl, dt, dr, db;
      coord_type         sl, st, sr, sb;
      logic [CELL_W-1:0] row;
      logic [CELL_W-1:0] col;
      logic              last;
   } beat_type;

   cells_type            cur_ff, q_entry;
   logic [NUM_CELLS-1:0] mask_ff, mask_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   beat_type             rsp_ff, beat;

   logic                 out_free;
   logic                 found;
   logic                 emit;
   logic [CELL_W-1:0]    sel_r, sel_c;
   logic [NUM_CELLS-1:0] sel_bit, rest, new_mask;

   assign q_entry = q_data;

   always_comb begin
      found   = 1'b0;
      sel_r   = '0;
      sel_c   = '0;
      sel_bit = '0;
      for (int r = 0; r < GRID; r++) begin
         for (int c = 0; c < GRID; c++) begin
            if (mask_ff[r*GRID+c] && !found) begin
               found   = 1'b1;
               sel_r   = CELL_W'(r);
               sel_c   = CELL_W'(c);
               sel_bit = NUM_CELLS'(1) << (r*GRID+c);
            end
         end
      end
      for (int r = 0; r < GRID; r++) begin
         for (int c = 0; c < GRID; c++) begin
            new_mask[r*GRID+c] = q_entry.row_live[r] & q_entry.col_live[c];
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign emit     = found && out_free;
   assign rest     = mask_ff & ~sel_bit;
   assign q_pop    = q_valid && ((mask_ff == '0) || (emit && (rest == '0)));

   always_comb begin
      beat.dl   = cur_ff.xd[sel_c];
      beat.dr   = cur_ff.xd[sel_c + 1'b1];
      beat.dt   = cur_ff.yd[sel_r];
      beat.db   = cur_ff.yd[sel_r + 1'b1];
      beat.sl   = cur_ff.xs[sel_c];
      beat.sr   = cur_ff.xs[sel_c + 1'b1];
      beat.st   = cur_ff.ys[sel_r];
      beat.sb   = cur_ff.ys[sel_r + 1'b1];
      beat.row  = sel_r;
      beat.col  = sel_c;
      beat.last = rest == '0;

      if (q_pop) begin
         mask_in = new_mask;
      end else if (emit) begin
         mask_in = rest;
      end else begin
         mask_in = mask_ff;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_entry;
      end
      if (emit) begin
         rsp_ff <= beat;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.out_dst_left   = rsp_ff.dl;
   assign rsp_bus.out_dst_top    = rsp_ff.dt;
   assign rsp_bus.out_dst_right  = rsp_ff.dr;
   assign rsp_bus.out_dst_bottom = rsp_ff.db;
   assign rsp_bus.out_src_left   = rsp_ff.sl;
   assign rsp_bus.out_src_top    = rsp_ff.st;
   assign rsp_bus.out_src_right  = rsp_ff.sr;
   assign rsp_bus.out_src_bottom = rsp_ff.sb;
   assign rsp_bus.cell_row       = rsp_ff.row;
   assign rsp_bus.cell_col       = rsp_ff.col;
   assign rsp_bus.last_cell      = rsp_ff.last;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Testbench for the nine-slice rectangle splitter: directed and random commands, cell checking.
module testbench;
   import nss_pkg::*;

   localparam int COORD_BITS     = COORD_BITS_DEF;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 20;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [MARGIN_W-1:0]          margin_type;

   typedef struct packed {
      coord_type  dst_left;
      coord_type  dst_top;
      coord_type  dst_right;
      coord_type  dst_bottom;
      coord_type  source_left;
      coord_type  source_top;
      coord_type  source_right;
      coord_type  source_bottom;
      margin_type margin_left;
      margin_type margin_top;
      margin_type margin_right;
      margin_type margin_bottom;
   } command_type;

   typedef struct packed {
      coord_type         dst_left;
      coord_type         dst_top;
      coord_type         dst_right;
      coord_type         dst_bottom;
      coord_type         src_left;
      coord_type         src_top;
      coord_type         src_right;
      coord_type         src_bottom;
      logic [CELL_W-1:0] cell_row;
      logic [CELL_W-1:0] cell_col;
      logic              last_cell;
   } cell_type;

   typedef struct {
      bit ok;
      int d[GRID+1];
      int s[GRID+1];
   } axis_cuts_type;

   class cell_scoreboard;
      cell_type expected_cells[$];
      int       failures;

      function int pending();
         return expected_cells.size();
      endfunction

      function axis_cuts_type split_axis(int lo, int hi, int slo, int shi, int m0, int m1);
         axis_cuts_type a;
         int w;
         int k;
         a.d = '{lo, lo + m0, hi - m1, hi};
         a.s = '{slo, slo + m0, shi - m1, shi};
         a.ok = (a.s[0] <= a.s[1]) && (a.s[1] <= a.s[2]) && (a.s[2] <= a.s[3]);
         if (!a.ok)
            return a;
         w = hi - lo;
         if (m0 + m1 > w) begin
            if (m0 >= w) begin
               for (int i = 1; i <= GRID; i++) begin
                  a.s[i] = a.s[0] + w;
                  a.d[i] = a.d[0] + w;
               end
            end else if (m1 >= w) begin
               for (int i = 0; i < GRID; i++) begin
                  a.s[i] = a.s[3] - w;
                  a.d[i] = a.d[3] - w;
               end
            end else begin
               k = a.d[3] - a.d[1];
               a.s[2] = a.s[3] - k;
               a.d[2] = a.d[3] - k;
            end
         end
         return a;
      endfunction

      function void note_command(command_type c);
         axis_cuts_type hx;
         axis_cuts_type vy;
         cell_type      item;
         cell_type      fresh[$];
         hx = split_axis(c.dst_left, c.dst_right, c.source_left, c.source_right,
                         c.margin_left, c.margin_right);
         vy = split_axis(c.dst_top, c.dst_bottom, c.source_top, c.source_bottom,
                         c.margin_top, c.margin_bottom);
         if (!hx.ok || !vy.ok)
            return;
         for (int r = 0; r < GRID; r++) begin
            if (vy.s[r] == vy.s[r+1])
               continue;
            for (int col = 0; col < GRID; col++) begin
               if (hx.s[col] == hx.s[col+1])
                  continue;
               item.dst_left   = coord_type'(hx.d[col]);
               item.dst_top    = coord_type'(vy.d[r]);
               item.dst_right  = coord_type'(hx.d[col+1]);
               item.dst_bottom = coord_type'(vy.d[r+1]);
               item.src_left   = coord_type'(hx.s[col]);
               item.src_top    = coord_type'(vy.s[r]);
               item.src_right  = coord_type'(hx.s[col+1]);
               item.src_bottom = coord_type'(vy.s[r+1]);
               item.cell_row   = r[CELL_W-1:0];
               item.cell_col   = col[CELL_W-1:0];
               item.last_cell  = 1'b0;
               fresh.push_back(item);
            end
         end
         if (fresh.size() > 0) begin
            item = fresh.pop_back();
            item.last_cell = 1'b1;
            fresh.push_back(item);
         end
         foreach (fresh[i])
            expected_cells.push_back(fresh[i]);
      endfunction

      function string describe(cell_type c);
         return $sformatf("dst(%0d,%0d,%0d,%0d) src(%0d,%0d,%0d,%0d) row %0d col %0d last %0b",
                          c.dst_left, c.dst_top, c.dst_right, c.dst_bottom,
                          c.src_left, c.src_top, c.src_right, c.src_bottom,
                          c.cell_row, c.cell_col, c.last_cell);
      endfunction

      function void check_cell(cell_type got);
         cell_type want;
         if (expected_cells.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected cell beat: %s", describe(got));
            return;
         end
         want = expected_cells.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10) begin
               $display("cell mismatch at %0t", $realtime);
               $display("  expected %s", describe(want));
               $display("  actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   hold_request = 1'b0;
   int   idle_cycles = 0;

   cell_scoreboard sb = new();

   nss_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   nss_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();

   nine_slice_rect_splitter #(.COORD_BITS(COORD_BITS)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic command_type make_command(int dl, int dt, int dr, int db,
                                                int sl, int st, int sr, int sbm,
                                                int ml, int mt, int mr, int mb);
      command_type c;
      c.dst_left      = coord_type'(dl);
      c.dst_top       = coord_type'(dt);
      c.dst_right     = coord_type'(dr);
      c.dst_bottom    = coord_type'(db);
      c.source_left   = coord_type'(sl);
      c.source_top    = coord_type'(st);
      c.source_right  = coord_type'(sr);
      c.source_bottom = coord_type'(sbm);
      c.margin_left   = margin_type'(ml);
      c.margin_top    = margin_type'(mt);
      c.margin_right  = margin_type'(mr);
      c.margin_bottom = margin_type'(mb);
      return c;
   endfunction

   function automatic void shape_axis(output coord_type lo, output coord_type hi,
                                      output coord_type slo, output coord_type shi,
                                      output margin_type m0, output margin_type m1);
      int a;
      int b;
      int len;
      int dlen;
      int start;
      if ($urandom_range(15) == 0) begin
         a = $urandom_range(16000);
         b = $urandom_range(16000);
      end else begin
         a = ($urandom_range(3) == 0) ? 0 : $urandom_range(24);
         b = ($urandom_range(3) == 0) ? 0 : $urandom_range(24);
      end
      len = a + b + (($urandom_range(4) == 0) ? 0 : $urandom_range(40));
      if ($urandom_range(15) == 0 && a + b > 0)
         len = a + b - 1;
      start = -32768 + int'($urandom_range(65535 - len));
      slo = coord_type'(start);
      shi = coord_type'(start + len);
      case ($urandom_range(7))
         0:       dlen = $urandom_range(a + b);
         1:       dlen = -int'($urandom_range(200));
         2:       dlen = a + b;
         3:       dlen = a;
         4:       dlen = b;
         default: dlen = a + b + $urandom_range(300);
      endcase
      start = -32768 + int'($urandom_range(65535));
      lo = coord_type'(start);
      hi = coord_type'(start + dlen);
      m0 = margin_type'(a);
      m1 = margin_type'(b);
   endfunction

   function automatic command_type random_command();
      command_type  c;
      logic [191:0] noise;
      if ($urandom_range(4) == 0) begin
         noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         c = noise[$bits(command_type)-1:0];
      end else begin
         shape_axis(c.dst_left, c.dst_right, c.source_left, c.source_right,
                    c.margin_left, c.margin_right);
         shape_axis(c.dst_top, c.dst_bottom, c.source_top, c.source_bottom,
                    c.margin_top, c.margin_bottom);
      end
      return c;
   endfunction

   task automatic issue_commands(input command_type cmds[$]);
      int burst;
      int gap;
      bit taken;
      burst = $urandom_range(1, 16);
      foreach (cmds[i]) begin
         if (burst == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst = $urandom_range(1, 16);
         end
         req_bus.valid         <= 1'b1;
         req_bus.dst_left      <= cmds[i].dst_left;
         req_bus.dst_top       <= cmds[i].dst_top;
         req_bus.dst_right     <= cmds[i].dst_right;
         req_bus.dst_bottom    <= cmds[i].dst_bottom;
         req_bus.source_left   <= cmds[i].source_left;
         req_bus.source_top    <= cmds[i].source_top;
         req_bus.source_right  <= cmds[i].source_right;
         req_bus.source_bottom <= cmds[i].source_bottom;
         req_bus.margin_left   <= cmds[i].margin_left;
         req_bus.margin_top    <= cmds[i].margin_top;
         req_bus.margin_right  <= cmds[i].margin_right;
         req_bus.margin_bottom <= cmds[i].margin_bottom;
         do begin
            @(negedge clock);
            taken = req_bus.ready;
            if (taken)
               sb.note_command(cmds[i]);
            @(posedge clock);
         end while (!taken);
         burst--;
      end
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random(input int count);
      command_type batch[$];
      repeat (count) batch.push_back(random_command());
      issue_commands(batch);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // receiver: random stall patterns, with a long hold-off on request
   initial begin
      int mode;
      int span;
      rsp_bus.ready = 1'b0;
      forever begin
         mode = $urandom_range(3);
         span = $urandom_range(20, 150);
         for (int i = 0; i < span; i++) begin
            @(posedge clock);
            if (hold_request) begin
               hold_request = 1'b0;
               rsp_bus.ready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= $urandom_range(1);
               2:       rsp_bus.ready <= (i % 5) != 0;
               default: rsp_bus.ready <= (i % 7) < 2;
            endcase
         end
      end
   end

   // check cell beats and watch for a hang
   always @(negedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_cell('{rsp_bus.out_dst_left, rsp_bus.out_dst_top,
                         rsp_bus.out_dst_right, rsp_bus.out_dst_bottom,
                         rsp_bus.out_src_left, rsp_bus.out_src_top,
                         rsp_bus.out_src_right, rsp_bus.out_src_bottom,
                         rsp_bus.cell_row, rsp_bus.cell_col, rsp_bus.last_cell});
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      command_type directed[$];
      req_bus.valid         = 1'b0;
      req_bus.dst_left      = '0;
      req_bus.dst_top       = '0;
      req_bus.dst_right     = '0;
      req_bus.dst_bottom    = '0;
      req_bus.source_left   = '0;
      req_bus.source_top    = '0;
      req_bus.source_right  = '0;
      req_bus.source_bottom = '0;
      req_bus.margin_left   = '0;
      req_bus.margin_top    = '0;
      req_bus.margin_right  = '0;
      req_bus.margin_bottom = '0;

      directed.push_back(make_command(0, 0, 100, 80, 0, 0, 30, 30, 10, 10, 10, 10));
      directed.push_back(make_command(0, 0, 100, 80, 5, 5, 25, 25, 0, 0, 0, 0));
      directed.push_back(make_command(0, 0, 100, 80, 0, 0, 10, 30, 6, 5, 6, 5));
      directed.push_back(make_command(0, 0, 100, 80, 0, 0, 30, 10, 5, 6, 5, 6));
      directed.push_back(make_command(0, 0, 5, 5, 0, 0, 20, 20, 8, 8, 4, 4));
      directed.push_back(make_command(0, 0, 5, 5, 0, 0, 20, 20, 3, 3, 7, 7));
      directed.push_back(make_command(0, 0, 10, 10, 0, 0, 20, 20, 6, 6, 6, 6));
      directed.push_back(make_command(50, 40, 10, 0, 0, 0, 20, 20, 3, 3, 3, 3));
      directed.push_back(make_command(32767, 32767, -32768, -32768,
                                      -32768, -32768, -32700, -32700, 10, 10, 10, 10));
      directed.push_back(make_command(0, 0, 100, 100, 7, 7, 7, 7, 0, 0, 0, 0));
      directed.push_back(make_command(-32768, -32768, 32767, 32767,
                                      -32768, -32768, 32767, 32767,
                                      32767, 32767, 32767, 32767));
      directed.push_back(make_command(-100, -32768, 100, 32767,
                                      -32768, -32768, 32767, 0, 32767, 32767, 0, 0));
      directed.push_back(make_command(10, 10, 10, 10, 0, 0, 20, 20, 0, 0, 0, 0));
      directed.push_back(make_command(10, 10, 10, 10, 0, 0, 20, 20, 4, 4, 4, 4));
      directed.push_back(make_command(0, 0, 20, 20, 0, 0, 20, 20, 8, 8, 12, 12));
      directed.push_back(make_command(0, 0, 8, 8, 0, 0, 20, 20, 8, 8, 5, 5));
      directed.push_back(make_command(0, 0, 7, 7, 0, 0, 20, 20, 3, 2, 7, 7));
      directed.push_back(make_command(0, 0, 60, 60, 0, 0, 30, 30, 0, 10, 5, 0));
      directed.push_back(make_command(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_command(-1, -1, -1, -1, -1, -1, -1, -1,
                                      32767, 32767, 32767, 32767));
      directed.push_back(make_command(0, 0, 50, 50, 0, 0, 10, 10, 10, 0, 0, 10));
      directed.push_back(make_command(100, 100, 90, 90, 0, 0, 20, 20, 0, 0, 5, 5));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      issue_commands(directed);
      wait_drained();

      run_random(180);

      // hold the cell channel off while commands keep coming
      hold_request = 1'b1;
      run_random(60);
      wait_drained();

      run_random(210);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
